>>> sv/go_back_n_packet_receiver_core_macros.svh
// Assertion helpers for the go-back-N receiver.
// Both expect clk and rst_n in scope at the point of use.
`ifndef GO_BACK_N_PACKET_RECEIVER_CORE_MACROS_SVH
`define GO_BACK_N_PACKET_RECEIVER_CORE_MACROS_SVH

// Consequent checked in the same cycle.
`define GBNR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define GBNR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gbnr_pkg.sv
// ----------------------------------------------------------------------------
// gbnr_pkg
// Types and fixed constants of the go-back-N packet receiver.
// ----------------------------------------------------------------------------
package gbnr_pkg;

  localparam int HEADER_BYTES = 6;

  // header byte positions
  localparam int POS_CHK_LO = 1;
  localparam int POS_LEN    = 2;
  localparam int POS_SEQ_HI = 3;

  localparam int SEQ_W = 24;
  localparam int ACK_W = SEQ_W + 1;

  typedef enum logic [2:0] {
    S_RECV,
    S_CHECK,
    S_PAY_RD,
    S_PAY_WR,
    S_ACK
  } state_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_ACK     = 1'b1
  } kind_t;

endpackage

>>> sv/gbnr_ram.sv
// ----------------------------------------------------------------------------
// gbnr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gbnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 58
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/go_back_n_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// go_back_n_packet_receiver_core
// Go-back-N receiver for fixed-size packets arriving one byte per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_byte): one packet byte per item,
// PACKET_BYTES bytes per packet: checksum high, checksum low, length,
// 24-bit sequence number, then payload. Bytes are taken one per cycle while in_stall is low.
// Payload bytes go into a RAM as they arrive; the checksum is folded on the fly.
// Result channel (out_valid / out_stall / out_*): after the last byte of a
// packet the block checks it (S_CHECK), then, for an in-order packet
// with a good checksum, sends each payload byte (out_kind 0) and finally one
// acknowledgement (out_kind 1, out_last 1). Any other packet gives only the
// acknowledgement of the last in-order number, or -1 if none yet.
// Each payload byte is first read from the RAM (S_PAY_RD), then loaded into
// the output register (S_PAY_WR). in_stall is high from the last byte until
// the ack loads. A stalled result holds in the output register; the run
// waits behind it.
// Reset (rst_n low, synchronous) clears the byte position, checksum state and
// the expected sequence number. The payload RAM needs no clearing.
// ----------------------------------------------------------------------------
`include "go_back_n_packet_receiver_core_macros.svh"

module go_back_n_packet_receiver_core #(
  parameter int PACKET_BYTES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_kind,
  output logic [7:0]               out_data,
  output logic signed [gbnr_pkg::ACK_W-1:0] out_ack_number,
  output logic                     out_last
);

  import gbnr_pkg::*;

  localparam int PAY_MAX = PACKET_BYTES - HEADER_BYTES;
  localparam int PW      = $clog2(PACKET_BYTES);
  localparam int AW      = $clog2(PAY_MAX);
  localparam int CW      = $clog2(PAY_MAX + 1);

  localparam logic [PW-1:0] POS_LAST  = PW'(PACKET_BYTES - 1);
  localparam logic [PW-1:0] POS_HDR   = PW'(HEADER_BYTES);
  localparam logic [7:0]    PAY_MAX_B = 8'(PAY_MAX);

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  state_t            state_r, state_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [15:0]       chk_r, chk_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [SEQ_W-1:0]  recv_r, recv_nxt;
  logic [SEQ_W-1:0]  exp_r, exp_nxt;
  logic              good_r, good_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic [ACK_W-1:0]  out_ack_r, out_ack_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc;
  logic              out_free;
  logic [15:0]       addend;
  logic [7:0]        len_clamp;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  assign in_stall = (state_r != S_RECV);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // pair the pending even byte with the odd byte; a lone last byte adds alone
  assign addend = pos_r[0] ? {in_byte, pend_r} : {8'd0, in_byte};

  always_comb begin
    if (len_r[7]) begin
      len_clamp = 8'd0;
    end else if (len_r > PAY_MAX_B) begin
      len_clamp = PAY_MAX_B;
    end else begin
      len_clamp = len_r;
    end
  end

  assign ram_we    = in_acc && (pos_r >= POS_HDR);
  assign ram_waddr = AW'(pos_r - POS_HDR);
  assign ram_re    = (state_r == S_PAY_RD);

  gbnr_ram #(
    .WIDTH (8),
    .DEPTH (PAY_MAX)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    pend_nxt      = pend_r;
    chk_nxt       = chk_r;
    len_nxt       = len_r;
    recv_nxt      = recv_r;
    exp_nxt       = exp_r;
    good_nxt      = good_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_ack_nxt   = out_ack_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_RECV: begin
        if (in_acc) begin
          if (pos_r == '0) begin
            chk_nxt = {in_byte, 8'd0};
            sum_nxt = 16'd0;
          end else if (pos_r == PW'(POS_CHK_LO)) begin
            chk_nxt = {chk_r[15:8], in_byte};
          end else begin
            if (pos_r == PW'(POS_LEN)) begin
              len_nxt = in_byte;
            end else if (pos_r == PW'(POS_SEQ_HI)) begin
              recv_nxt = {16'd0, in_byte};
            end else if (pos_r < POS_HDR) begin
              recv_nxt = {recv_r[15:0], in_byte};
            end
            if (!pos_r[0]) begin
              pend_nxt = in_byte;
            end
            if (pos_r[0] || pos_r == POS_LAST) begin
              sum_nxt = fold_add(sum_r, addend);
            end
          end
          if (pos_r == POS_LAST) begin
            pos_nxt   = '0;
            state_nxt = S_CHECK;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_CHECK: begin
        good_nxt = (sum_r == ~chk_r) && (recv_r == exp_r);
        cnt_nxt  = CW'(len_clamp);
        idx_nxt  = '0;
        if ((sum_r == ~chk_r) && (recv_r == exp_r) && (len_clamp != 8'd0)) begin
          state_nxt = S_PAY_RD;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_PAY_RD: begin
        state_nxt = S_PAY_WR;
      end
      S_PAY_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_PAYLOAD;
          out_data_nxt  = ram_rdata;
          out_ack_nxt   = '0;
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_r - 1'b1;
          idx_nxt       = idx_r + 1'b1;
          state_nxt     = (cnt_r == CW'(1)) ? S_ACK : S_PAY_RD;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_data_nxt  = 8'd0;
          out_last_nxt  = 1'b1;
          if (good_r) begin
            out_ack_nxt = {1'b0, exp_r};
            exp_nxt     = exp_r + 1'b1;
          end else if (exp_r == '0) begin
            out_ack_nxt = '1;
          end else begin
            out_ack_nxt = {1'b0, exp_r - 1'b1};
          end
          state_nxt = S_RECV;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RECV;
      pos_r       <= '0;
      sum_r       <= '0;
      pend_r      <= '0;
      chk_r       <= '0;
      len_r       <= '0;
      recv_r      <= '0;
      exp_r       <= '0;
      good_r      <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      pend_r      <= pend_nxt;
      chk_r       <= chk_nxt;
      len_r       <= len_nxt;
      recv_r      <= recv_nxt;
      exp_r       <= exp_nxt;
      good_r      <= good_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_ack_r  <= out_ack_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data       = out_data_r;
  assign out_ack_number = out_ack_r;
  assign out_last       = out_last_r;

  `GBNR_ASSERT_NEXT(a_last_byte_checks, in_acc && (pos_r == POS_LAST),
    (state_r == S_CHECK) && (pos_r == '0), "last byte did not start the packet check")

  `GBNR_ASSERT_NEXT(a_ack_advances, (state_r == S_ACK) && out_free && good_r,
    exp_r == SEQ_W'($past(exp_r) + 1'b1), "expected number did not advance on ack")

  `GBNR_ASSERT_NOW(a_run_in_range, (state_r == S_PAY_RD) || (state_r == S_PAY_WR),
    (cnt_r != '0) && (cnt_r <= CW'(PAY_MAX)) && good_r, "payload run count out of range")

endmodule
